// ----- hw/rtl/mask_transition_bounding_box_top_macros.svh -----
// Assertion macros of the mask transition bounding box RTL.
`ifndef MASK_TRANSITION_BOUNDING_BOX_TOP_MACROS_SVH
`define MASK_TRANSITION_BOUNDING_BOX_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MTBB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mtbb assertion failed");

// Next-cycle implication, disabled while reset is held.
`define MTBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mtbb assertion failed");

`endif

// ----- hw/rtl/mtbb_pkg.sv -----
// Types and constants of the mask transition bounding box block.
package mtbb_pkg;

  localparam int COORD_W = 12;
  localparam int MASK_W  = 8;
  localparam int CFG_IDX_W = 3;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [MASK_W-1:0]  mask_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t REG_BOX_FIRST_X = 3'd0;
  localparam cfg_idx_t REG_BOX_LAST_X  = 3'd1;
  localparam cfg_idx_t REG_BOX_FIRST_Y = 3'd2;
  localparam cfg_idx_t REG_BOX_LAST_Y  = 3'd3;

  // Scan box
  typedef struct packed {
    coord_t first_x;
    coord_t last_x;
    coord_t first_y;
    coord_t last_y;
  } box_t;

  localparam box_t BOX_RESET = '{
    first_x: 12'd0,
    last_x:  12'd4095,
    first_y: 12'd0,
    last_y:  12'd4095
  };

  // Pixel item as it sits in the compare stage
  typedef struct packed {
    coord_t row;
    coord_t col;
    mask_t  pix;
    logic   row_diff;
    logic   is_top;
    logic   is_last;
  } pix_item_t;

  // Tracked bounds
  typedef struct packed {
    coord_t min_row;
    coord_t max_row;
    coord_t min_col;
    coord_t max_col;
  } bounds_t;

  // Crossed start values of the bounds for a given box
  function automatic bounds_t start_bounds(box_t box);
    bounds_t b;
    b.min_row = box.last_y;
    b.max_row = box.first_y;
    b.min_col = box.last_x;
    b.max_col = box.first_x;
    return b;
  endfunction

endpackage

// ----- hw/rtl/mtbb_line_store.sv -----
// Single-port line store holding the top-row mask values, registered read.
module mtbb_line_store #(
  parameter int DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   addr,
  input  mtbb_pkg::mask_t            wdata,
  output mtbb_pkg::mask_t            rdata
);
  import mtbb_pkg::*;

  mask_t mem [DEPTH];
  mask_t rdata_r;

  // One access per cycle: write in the top row, read below it
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/mtbb_bounds.sv -----
// Min/max tracker of multicolour rows and columns, one pixel item per step.
module mtbb_bounds (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 restart,
  input  mtbb_pkg::box_t       restart_box,
  input  mtbb_pkg::box_t       box,
  input  logic                 step,
  input  mtbb_pkg::pix_item_t  item,
  input  mtbb_pkg::mask_t      top_val,
  output mtbb_pkg::bounds_t    upd
);
  import mtbb_pkg::*;

  bounds_t bnd_r, bnd_nxt;
  logic    col_diff;

  // Fold the current pixel into the bounds
  always_comb begin
    col_diff = !item.is_top && (item.pix != top_val);
    upd = bnd_r;
    if (item.row_diff) begin
      if (item.row < bnd_r.min_row) upd.min_row = item.row;
      if (item.row > bnd_r.max_row) upd.max_row = item.row;
    end
    if (col_diff) begin
      if (item.col < bnd_r.min_col) upd.min_col = item.col;
      if (item.col > bnd_r.max_col) upd.max_col = item.col;
    end
  end

  // Next bounds: restart on config, fresh scan after the box's last pixel
  always_comb begin
    bnd_nxt = bnd_r;
    if (restart) begin
      bnd_nxt = start_bounds(restart_box);
    end else if (step) begin
      bnd_nxt = item.is_last ? start_bounds(box) : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_r <= start_bounds(BOX_RESET);
    end else begin
      bnd_r <= bnd_nxt;
    end
  end

endmodule

// ----- hw/rtl/mask_transition_bounding_box_top.sv -----
// Top level of the mask transition bounding box block.
// Takes one 8-bit mask pixel per cycle in raster order over the configured box and,
// after the box's last pixel, delivers one item with the bounds of the rows and
// columns that hold a colour change (crossed start values if none). Throughput is
// one pixel per cycle. The last pixel passes through the compare stage register
// and then the result register. The compare stage also holds the registered read
// of the single-port top-row line store (MAX_LINE entries, one write or one read
// per pixel). The min/max result is registered as the item leaves that stage. The
// input stalls only while a finished result waits behind a full output register.
// The line store needs no clearing pass; it is filled by the top row of each scan.
// Any write to one of the four box registers restarts the scan.
module mask_transition_bounding_box_top #(
  parameter int MAX_LINE = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  mtbb_pkg::cfg_idx_t   cfg_index,
  input  mtbb_pkg::coord_t     cfg_data,
  // pixel input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mtbb_pkg::mask_t      in_mask_value,
  // result output
  output logic                 out_valid,
  input  logic                 out_ready,
  output mtbb_pkg::coord_t     out_first_row,
  output mtbb_pkg::coord_t     out_last_row,
  output mtbb_pkg::coord_t     out_first_col,
  output mtbb_pkg::coord_t     out_last_col
);
  import mtbb_pkg::*;

`include "mask_transition_bounding_box_top_macros.svh"

  localparam int AW = $clog2(MAX_LINE);
  localparam logic [AW-1:0] OFF_LAST = AW'(MAX_LINE - 1);

  box_t            box_r, box_nxt;
  logic            restart;
  coord_t          col_r, col_nxt, row_r, row_nxt;
  logic [AW-1:0]   off_r, off_nxt;
  mask_t           left_r, left_nxt;
  logic            accept;
  pix_item_t       in_item;
  logic            s1_v_r, s1_v_nxt;
  pix_item_t       s1_r;
  logic            s1_adv;
  mask_t           top_val;
  bounds_t         upd;
  logic            out_v_r, out_v_nxt;
  bounds_t         out_r;
  logic            col_end;

  // Configuration register writes
  always_comb begin
    box_nxt = box_r;
    restart = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_BOX_FIRST_X: begin box_nxt.first_x = cfg_data; restart = 1'b1; end
        REG_BOX_LAST_X:  begin box_nxt.last_x  = cfg_data; restart = 1'b1; end
        REG_BOX_FIRST_Y: begin box_nxt.first_y = cfg_data; restart = 1'b1; end
        REG_BOX_LAST_Y:  begin box_nxt.last_y  = cfg_data; restart = 1'b1; end
        default: restart = 1'b0;
      endcase
    end
  end

  // Handshake: compare stage drains unless a result waits for a full output
  assign s1_adv   = !s1_r.is_last || !out_v_r || out_ready;
  assign in_ready = !s1_v_r || s1_adv;
  assign accept   = in_valid && in_ready;

  // Classify the incoming pixel against its position in the box
  always_comb begin
    in_item.row      = row_r;
    in_item.col      = col_r;
    in_item.pix      = in_mask_value;
    left_nxt         = (col_r == box_r.first_x) ? in_mask_value : left_r;
    in_item.row_diff = (in_mask_value != left_nxt);
    in_item.is_top   = (row_r == box_r.first_y);
    col_end          = (col_r == box_r.last_x);
    in_item.is_last  = col_end && (row_r == box_r.last_y);
  end

  // Raster position and line store offset
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    off_nxt = off_r;
    if (restart) begin
      col_nxt  = box_nxt.first_x;
      row_nxt  = box_nxt.first_y;
      off_nxt  = '0;
    end else if (accept) begin
      if (in_item.is_last) begin
        col_nxt = box_r.first_x;
        row_nxt = box_r.first_y;
        off_nxt = '0;
      end else if (col_end) begin
        col_nxt = box_r.first_x;
        row_nxt = row_r + 1'b1;
        off_nxt = '0;
      end else begin
        col_nxt = col_r + 1'b1;
        off_nxt = (off_r == OFF_LAST) ? '0 : off_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r  <= BOX_RESET;
      col_r  <= BOX_RESET.first_x;
      row_r  <= BOX_RESET.first_y;
      off_r  <= '0;
      left_r <= '0;
    end else begin
      box_r <= box_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      off_r <= off_nxt;
      if (restart || (accept && in_item.is_last)) begin
        left_r <= '0;
      end else if (accept) begin
        left_r <= left_nxt;
      end
    end
  end

  // Top-row line store
  mtbb_line_store #(
    .DEPTH (MAX_LINE)
  ) u_line_store (
    .clk   (clk),
    .en    (accept),
    .we    (in_item.is_top),
    .addr  (off_r),
    .wdata (in_mask_value),
    .rdata (top_val)
  );

  // Compare stage register
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_item;
    end
  end

  // Bounds tracking
  mtbb_bounds u_bounds (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (restart),
    .restart_box (box_nxt),
    .box         (box_r),
    .step        (s1_v_r && s1_adv),
    .item        (s1_r),
    .top_val     (top_val),
    .upd         (upd)
  );

  // Result register
  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_v_r && s1_r.is_last && s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s1_r.is_last && s1_adv) begin
      out_r <= upd;
    end
  end

  assign out_valid     = out_v_r;
  assign out_first_row = out_r.min_row;
  assign out_last_row  = out_r.max_row;
  assign out_first_col = out_r.min_col;
  assign out_last_col  = out_r.max_col;

  // Checks
  `MTBB_ASSERT_NOW(a_stall_only_on_full_out, clk, rst_n, s1_v_r && !s1_adv, out_v_r && !out_ready)
  `MTBB_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !s1_v_r, in_ready)
  `MTBB_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, accept, s1_v_r)
  `MTBB_ASSERT_NEXT(a_restart_col, clk, rst_n, restart, col_r == box_r.first_x && off_r == '0)

endmodule
